// ===== hw/rtl/gf16c_pkg.sv =====
// ----------------------------------------------------------------------------
// gf16c_pkg
// Shared types, codes and field arithmetic for the GF(2^16) constant
// multiply/divide block.
// ----------------------------------------------------------------------------
package gf16c_pkg;

  localparam int unsigned GfWidth = 16;
  localparam logic [GfWidth:0] GfPoly = 17'h1100b;
  // one squaring cell per bit of the exponent 2^16-2
  localparam int unsigned NumCells = GfWidth;
  localparam int unsigned CfgIdxWidth = 8;

  typedef enum logic [1:0] {
    OpMul    = 2'd0,
    OpCoefDiv = 2'd1,
    OpDivCoef = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegCoefficient = 8'd0,
    RegOperation   = 8'd1
  } cfg_reg_e;

  // word travelling down the cell chain
  typedef struct packed {
    logic [GfWidth-1:0] acc;    // running power of the divisor
    logic [GfWidth-1:0] base;   // divisor raised to 2^k
    logic [GfWidth-1:0] num;    // dividend, or first factor
    logic [GfWidth-1:0] fac;    // second factor for a plain product
    op_e                op;
    logic               dz;
  } item_t;

  // carry-less product reduced by the field polynomial
  function automatic logic [GfWidth-1:0] gf_mul(input logic [GfWidth-1:0] a,
                                                 input logic [GfWidth-1:0] b);
    logic [2*GfWidth-2:0] p;
    p = '0;
    for (int i = 0; i < GfWidth; i++) begin
      if (b[i]) begin
        p = p ^ ((2*GfWidth-1)'(a) << i);
      end
    end
    for (int j = 2*GfWidth-2; j >= GfWidth; j--) begin
      if (p[j]) begin
        p = p ^ ((2*GfWidth-1)'(GfPoly) << (j - GfWidth));
      end
    end
    return p[GfWidth-1:0];
  endfunction

endpackage

// ===== hw/rtl/gf16c_cell.sv =====
// ----------------------------------------------------------------------------
// gf16c_cell
// One step of the exponentiation chain: hold a word, square its base and,
// where enabled, fold the base into the accumulator.
// ----------------------------------------------------------------------------
module gf16c_cell #(
  parameter bit MulEn = 1'b1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  gf16c_pkg::item_t  item_i,
  output logic              vld_o,
  output gf16c_pkg::item_t  item_o
);

  logic             vld_q;
  gf16c_pkg::item_t item_q;

  // hold valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // hold payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_i;
    end
  end

  // square the base, fold it in when this exponent bit is set
  always_comb begin
    item_o      = item_q;
    item_o.base = gf16c_pkg::gf_mul(item_q.base, item_q.base);
    if (MulEn) begin
      item_o.acc = gf16c_pkg::gf_mul(item_q.acc, item_q.base);
    end
  end

  assign vld_o = vld_q;

endmodule

// ===== hw/rtl/gf16c_final.sv =====
// ----------------------------------------------------------------------------
// gf16c_final
// Last stage: multiply the dividend by the inverse (or the plain factor)
// and register the result word.
// ----------------------------------------------------------------------------
module gf16c_final (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  gf16c_pkg::item_t                  item_i,
  output logic                              vld_o,
  output logic [gf16c_pkg::GfWidth-1:0]     res_o,
  output logic                              dz_o
);

  logic                          vld_q;
  logic [gf16c_pkg::GfWidth-1:0] res_q, res_d;
  logic                          dz_q;
  logic [gf16c_pkg::GfWidth-1:0] fac;

  // pick second factor and form the product
  always_comb begin
    fac   = (item_i.op == gf16c_pkg::OpMul) ? item_i.fac : item_i.acc;
    res_d = gf16c_pkg::gf_mul(item_i.num, fac);
    if (item_i.op == gf16c_pkg::OpNone || item_i.dz) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      dz_q  <= item_i.dz;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;
  assign dz_o  = dz_q;

endmodule

// ===== hw/rtl/gf16_const_mul_div.sv =====
// ----------------------------------------------------------------------------
// gf16_const_mul_div
// GF(2^16) multiply or divide by a configured coefficient.
// ----------------------------------------------------------------------------
// Takes one operand word per cycle while in_stall_o is low and returns one
// result word per operand, in order. Each word passes through the chain of 16
// squaring cells that raise the divisor to 2^16-2 (its inverse) and then the
// output multiply stage. Each stage moves on whenever the stage after it is
// empty or moving, so bubbles collapse and a stalled result does not stop
// input until the whole chain is full. Division by zero yields 0 with
// divide_by_zero set; operation code 3 yields 0.
module gf16_const_mul_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [gf16c_pkg::GfWidth-1:0]       operand_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gf16c_pkg::GfWidth-1:0]       field_result_o,
  output logic                                divide_by_zero_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gf16c_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [gf16c_pkg::GfWidth-1:0]       cfg_data_i
);

  localparam int unsigned N = gf16c_pkg::NumCells;

  logic [gf16c_pkg::GfWidth-1:0] coef_q;
  gf16c_pkg::op_e                op_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= gf16c_pkg::GfWidth'(1);
      op_q   <= gf16c_pkg::OpMul;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == gf16c_pkg::RegCoefficient) begin
        coef_q <= cfg_data_i;
      end else if (cfg_index_i == gf16c_pkg::RegOperation) begin
        op_q <= gf16c_pkg::op_e'(cfg_data_i[1:0]);
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  // build entry word
  gf16c_pkg::item_t entry;
  logic [gf16c_pkg::GfWidth-1:0] dvsr;

  always_comb begin
    dvsr       = (op_q == gf16c_pkg::OpCoefDiv) ? operand_i : coef_q;
    entry.acc  = gf16c_pkg::GfWidth'(1);
    entry.base = dvsr;
    entry.num  = (op_q == gf16c_pkg::OpCoefDiv) ? coef_q : operand_i;
    entry.fac  = coef_q;
    entry.op   = op_q;
    entry.dz   = (op_q == gf16c_pkg::OpCoefDiv || op_q == gf16c_pkg::OpDivCoef)
                 && (dvsr == '0);
  end

  // chain of cells
  gf16c_pkg::item_t items [N+1];
  logic [N:0]       vlds;
  logic [N:0]       ens;   // ens[N] enables the final stage
  logic             fin_vld;

  assign items[0] = entry;
  assign vlds[0]  = in_valid_i;

  for (genvar k = 0; k < N; k++) begin : g_cell
    gf16c_cell #(
      .MulEn (k != 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (ens[k]),
      .vld_i  (vlds[k]),
      .item_i (items[k]),
      .vld_o  (vlds[k+1]),
      .item_o (items[k+1])
    );
  end

  // advance a stage when the next one is empty or advancing
  always_comb begin
    ens[N] = !fin_vld || !out_stall_i;
    for (int k = N - 1; k >= 0; k--) begin
      ens[k] = !vlds[k+1] || ens[k+1];
    end
  end

  gf16c_final u_final (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (ens[N]),
    .vld_i  (vlds[N]),
    .item_i (items[N]),
    .vld_o  (fin_vld),
    .res_o  (field_result_o),
    .dz_o   (divide_by_zero_o)
  );

  assign in_stall_o  = !ens[0];
  assign out_valid_o = fin_vld;

endmodule
